FILE: rtl/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg: shared types and constants of the poll scheduler
// Request and result payloads, the decoded command and the backoff function.
// ----------------------------------------------------------------------------
package psb_pkg;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_SCAN   = 2'd1,
    FUNC_REPORT = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_e;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_NONE   = 2'd2;

  localparam logic [31:0] DEFAULT_PERIOD = 32'd30;
  localparam logic [31:0] BACKOFF_BASE   = 32'd250;
  localparam logic [31:0] BACKOFF_CAP    = 32'd1500;
  localparam logic [7:0]  BACKOFF_STEPS  = 8'd4;
  localparam logic [7:0]  FAIL_MAX       = 8'd255;
  localparam logic [3:0]  MAX_RESULTS    = 4'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [7:0]  device_id;
    logic [31:0] interval_ms;
    logic [2:0]  entry_slot;
    logic [3:0]  poll_code;
    logic [31:0] maximum_delay;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_out;
    logic        last;
    logic [31:0] delay_ms;
    logic [3:0]  round_error;
  } out_res_t;

  // Decoded command passed from front to back
  typedef struct packed {
    func_e       op;
    logic [31:0] now_ms;
    logic [7:0]  device_id;
    logic [31:0] interval_ms;   // zero period already replaced by the default
    logic [2:0]  entry_slot;
    logic [3:0]  poll_code;
    logic [31:0] maximum_delay;
  } cmd_t;

  // Backoff delay for a given (already raised) failure count
  function automatic logic [31:0] backoff_for(input logic [7:0] fails);
    logic [31:0] b;
    if (fails == 8'd0) begin
      b = 32'd0;
    end else if (fails >= BACKOFF_STEPS) begin
      b = BACKOFF_CAP;
    end else begin
      b = BACKOFF_BASE << (fails - 8'd1);
    end
    return b;
  endfunction

endpackage

FILE: rtl/psb_front.sv
// ----------------------------------------------------------------------------
// psb_front: request intake of the poll scheduler
// Accepts requests, decodes them into commands and buffers them in a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module psb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  psb_pkg::in_req_t in_req_i,
  output logic             cmd_valid_o,
  output psb_pkg::cmd_t    cmd_o,
  input  logic             cmd_pop_i
);
  import psb_pkg::*;

  localparam int unsigned QueueDepth = 2;

  cmd_t       q_mem [QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_c;
  logic       push;
  logic       pop;

  // Decode the request
  always_comb begin
    cmd_c.op            = func_e'(in_req_i.func);
    cmd_c.now_ms        = in_req_i.now_ms;
    cmd_c.device_id     = in_req_i.device_id;
    cmd_c.interval_ms   = (in_req_i.interval_ms == 32'd0) ? DEFAULT_PERIOD
                                                          : in_req_i.interval_ms;
    cmd_c.entry_slot    = in_req_i.entry_slot;
    cmd_c.poll_code     = in_req_i.poll_code;
    cmd_c.maximum_delay = in_req_i.maximum_delay;
  end

  assign in_stall_o  = (count_q == 2'(QueueDepth));
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the decoded command
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_c;
    end
  end

endmodule

FILE: rtl/psb_back.sv
// ----------------------------------------------------------------------------
// psb_back: command execution of the poll scheduler
// Holds the device table in a memory, walks it one entry per cycle (a stalled
// scan result holds the walk) for add, scan and query, and updates one entry for report.
// ----------------------------------------------------------------------------
module psb_back #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  psb_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psb_pkg::out_res_t out_res_o
);
  import psb_pkg::*;

  localparam int unsigned IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > 3) ? CW : 3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVAL = 5'b00010,
    ST_WR   = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] period;
    logic [31:0] deadline;
    logic [7:0]  fails;
  } entry_t;

  entry_t          table_mem [MAX_ENTRIES];
  entry_t          rdata_q;
  entry_t          wdata;
  logic [IW-1:0]   waddr;
  logic            we;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   used_q, used_d;
  logic [3:0]      fe_q, fe_d;
  logic            pend_v_q, pend_v_d;
  logic [IW-1:0]   pend_slot_q, pend_slot_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [31:0]     dmin_q, dmin_d;
  out_res_t        res_q, res_d;
  out_res_t        out_q;
  logic            out_valid_q;

  logic            out_free;
  logic            emit;
  out_res_t        emit_res;
  logic [31:0]     ahead;
  logic            due;
  logic            last_entry;
  logic [31:0]     dnew;
  logic [7:0]      nfails;
  logic [31:0]     ndead;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Due test on the current entry: deadline zero, reached, or wrapped past
  assign ahead      = rdata_q.deadline - cmd_q.now_ms;
  assign due        = (rdata_q.deadline == 32'd0) || (ahead == 32'd0) ||
                      (ahead[31] && (ahead[30:0] != 31'd0));
  assign last_entry = ((CW'(idx_q) + CW'(1)) == used_q);
  assign dnew       = (ahead < dmin_q) ? ahead : dmin_q;

  // Report update of the addressed entry
  always_comb begin
    if (cmd_q.poll_code == 4'd0) begin
      nfails = 8'd0;
      ndead  = cmd_q.now_ms + rdata_q.period;
    end else begin
      nfails = (rdata_q.fails == FAIL_MAX) ? FAIL_MAX : rdata_q.fails + 8'd1;
      ndead  = cmd_q.now_ms + backoff_for(nfails);
    end
  end

  // Sequence the commands
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    used_d      = used_q;
    fe_d        = fe_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    cnt_d       = cnt_q;
    dmin_d      = dmin_q;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata_q;
    emit        = 1'b0;
    emit_res    = res_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = (cmd_i.op == FUNC_REPORT) ? IW'(cmd_i.entry_slot) : '0;
          cnt_d     = 4'd0;
          pend_v_d  = 1'b0;
          dmin_d    = cmd_i.maximum_delay;
          res_d     = '{status: STATUS_REJECT, slot_out: 3'd0, last: 1'b1,
                        delay_ms: 32'd0, round_error: 4'd0};
          state_d   = ST_EVAL;
          case (cmd_i.op)
            FUNC_ADD: begin
              if (used_q >= CW'(MAX_ENTRIES)) begin
                state_d = ST_OUT;
              end else if (used_q == '0) begin
                state_d = ST_WR;
              end
            end
            FUNC_SCAN: begin
              fe_d = 4'd0;
              if (used_q == '0) begin
                state_d = ST_OUT;
              end
            end
            FUNC_REPORT: begin
              if (CMPW'(cmd_i.entry_slot) >= CMPW'(used_q)) begin
                state_d = ST_OUT;
              end
            end
            FUNC_QUERY: begin
              res_d.delay_ms = 32'd1;
              if (used_q == '0) begin
                state_d = ST_OUT;
              end else if (cmd_i.maximum_delay == 32'd0) begin
                res_d.status = STATUS_OK;
                state_d      = ST_OUT;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_EVAL: begin
        case (cmd_q.op)
          FUNC_ADD: begin
            if (rdata_q.id == cmd_q.device_id) begin
              state_d = ST_OUT;
            end else if (last_entry) begin
              state_d = ST_WR;
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end
          FUNC_SCAN: begin
            if (due) begin
              // hold while a pending result cannot leave
              if (!pend_v_q || out_free) begin
                if (pend_v_q) begin
                  emit     = 1'b1;
                  emit_res = '{status: STATUS_OK, slot_out: 3'(pend_slot_q),
                               last: 1'b0, delay_ms: 32'd0, round_error: fe_q};
                end
                pend_v_d    = 1'b1;
                pend_slot_d = idx_q;
                cnt_d       = 4'(cnt_q + 4'd1);
                if ((4'(cnt_q + 4'd1) == MAX_RESULTS) || last_entry) begin
                  state_d = ST_FIN;
                end else begin
                  idx_d = idx_q + IW'(1);
                end
              end
            end else if (last_entry) begin
              state_d = ST_FIN;
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end
          FUNC_REPORT: begin
            we             = 1'b1;
            wdata.deadline = ndead;
            wdata.fails    = nfails;
            if ((cmd_q.poll_code != 4'd0) && (fe_q == 4'd0)) begin
              fe_d = cmd_q.poll_code;
            end
            res_d   = '{status: STATUS_OK, slot_out: cmd_q.entry_slot, last: 1'b1,
                        delay_ms: ndead, round_error: 4'd0};
            state_d = ST_OUT;
          end
          FUNC_QUERY: begin
            res_d.status = STATUS_OK;
            if (due) begin
              res_d.delay_ms = 32'd1;
              state_d        = ST_OUT;
            end else begin
              dmin_d = dnew;
              if (last_entry) begin
                res_d.delay_ms = (dnew == 32'd0) ? 32'd1 : dnew;
                state_d        = ST_OUT;
              end else begin
                idx_d = idx_q + IW'(1);
              end
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_WR: begin
        we      = 1'b1;
        waddr   = IW'(used_q);
        wdata   = '{id: cmd_q.device_id, period: cmd_q.interval_ms,
                    deadline: 32'd0, fails: 8'd0};
        used_d  = used_q + CW'(1);
        res_d   = '{status: STATUS_OK, slot_out: 3'(used_q), last: 1'b1,
                    delay_ms: 32'd0, round_error: 4'd0};
        state_d = ST_OUT;
      end

      ST_FIN: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_res = pend_v_q
                   ? '{status: STATUS_OK, slot_out: 3'(pend_slot_q), last: 1'b1,
                       delay_ms: 32'd0, round_error: fe_q}
                   : '{status: STATUS_NONE, slot_out: 3'd0, last: 1'b1,
                       delay_ms: 32'd0, round_error: fe_q};
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_res             = res_q;
          emit_res.round_error = fe_q;
          state_d              = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      fe_q        <= 4'd0;
      pend_v_q    <= 1'b0;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      fe_q     <= fe_d;
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    idx_q       <= idx_d;
    pend_slot_q <= pend_slot_d;
    dmin_q      <= dmin_d;
    res_q       <= res_d;
    if (emit) begin
      out_q <= emit_res;
    end
  end

  // Table memory: read data follows the next index
  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
    rdata_q <= table_mem[idx_d];
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(MAX_ENTRIES))
    else $error("table fill count beyond capacity");

  a_pend_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (state_q == ST_EVAL || state_q == ST_FIN))
    else $error("pending scan result outside a scan walk");

  a_write_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ((state_q == ST_EVAL && cmd_q.op == FUNC_REPORT) || state_q == ST_WR))
    else $error("table write outside add or report");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WR |=> used_q == $past(used_q) + CW'(1))
    else $error("add did not grow the table");

  a_scan_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_RESULTS)
    else $error("scan produced too many results");

endmodule

FILE: rtl/poll_scheduler_backoff.sv
// Flow: the back end runs one request at a time and examines one table entry
//   per cycle while walking the table memory; a stalled result holds the walk.
//   Meanwhile the front end queues up to two further requests.
// Reset: rst_ni clears the table fill count, round error, queue and output
//   valid at once; table contents are written by add before use.
// ----------------------------------------------------------------------------
// poll_scheduler_backoff: polled device scheduler with exponential backoff
// Front end decodes and queues requests, back end runs them on the table.
// ----------------------------------------------------------------------------
module poll_scheduler_backoff #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  psb_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psb_pkg::out_res_t out_res_o
);
  import psb_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Decode and queue requests
  psb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Execute commands on the table
  psb_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the poll scheduler with exponential backoff
// Sends add, scan, report and query requests in random bursts, predicts each
// result from a private copy of the device table, and checks every result
// field against it while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import psb_pkg::*;

  localparam int unsigned TABLE_SIZE   = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_REQS  = 190;
  localparam int unsigned HAMMER_REQS  = 260;
  localparam int unsigned HAMMER_AT    = 100;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;

  // Request plus a flag that holds it back until all results are in
  typedef struct packed {
    logic    wait_idle;
    in_req_t req;
  } stim_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;

  stim_t    poll_req_q[$];
  out_res_t sched_res_q[$];

  // Private copy of the device table
  logic [7:0]  dev_id      [TABLE_SIZE];
  logic [31:0] poll_period [TABLE_SIZE];
  logic [31:0] next_due    [TABLE_SIZE];
  logic [7:0]  fail_cnt    [TABLE_SIZE];
  int unsigned fill_cnt;
  logic [3:0]  round_err;

  int unsigned total_reqs = 0;
  int unsigned req_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned due_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned func_cnt [4] = '{default: 0};

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 60;
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;

  always #5 clk_i = ~clk_i;

  poll_scheduler_backoff #(
    .MAX_ENTRIES(TABLE_SIZE)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res)
  );

  // Deadline reached, with a zero deadline always due
  function automatic bit is_due(input logic [31:0] now, input logic [31:0] when);
    logic [31:0] diff;
    diff = now - when;
    return (when == 32'd0) || !diff[31];
  endfunction

  // Apply one request to the table copy and queue the results it yields
  function automatic void run_scheduler(input in_req_t r);
    out_res_t    res;
    logic [7:0]  due_mask;
    logic [31:0] d;
    logic [31:0] c;
    bit          dup;
    int unsigned k;
    int          tail;
    res = '0;
    res.last = 1'b1;
    case (func_e'(r.func))
      FUNC_ADD: begin
        dup = (fill_cnt >= TABLE_SIZE);
        for (k = 0; k < fill_cnt; k++) begin
          if (dev_id[k] == r.device_id) dup = 1'b1;
        end
        if (dup) begin
          res.status = STATUS_REJECT;
        end else begin
          dev_id[fill_cnt] = r.device_id;
          poll_period[fill_cnt] = (r.interval_ms == 32'd0) ? DEFAULT_PERIOD
                                                           : r.interval_ms;
          res.slot_out = fill_cnt[2:0];
          fill_cnt++;
        end
      end
      FUNC_SCAN: begin
        // a scan opens a new error round
        round_err = '0;
        due_mask = '0;
        tail = -1;
        for (k = 0; k < fill_cnt; k++) begin
          if (is_due(r.now_ms, next_due[k])) begin
            due_mask[k] = 1'b1;
            tail = k;
          end
        end
        if (fill_cnt == 0) begin
          res.status = STATUS_REJECT;
          sched_res_q.push_back(res);
        end else if (tail < 0) begin
          res.status = STATUS_NONE;
          sched_res_q.push_back(res);
        end else begin
          for (k = 0; k < fill_cnt; k++) begin
            if (due_mask[k]) begin
              res.status = STATUS_OK;
              res.slot_out = k[2:0];
              res.last = (int'(k) == tail);
              sched_res_q.push_back(res);
              due_cnt++;
            end
          end
        end
      end
      FUNC_REPORT: begin
        if (r.entry_slot >= fill_cnt) begin
          res.status = STATUS_REJECT;
        end else begin
          if (r.poll_code == 4'd0) begin
            fail_cnt[r.entry_slot] = 8'd0;
            next_due[r.entry_slot] = r.now_ms + poll_period[r.entry_slot];
          end else begin
            // saturate the failure count and back off exponentially
            if (fail_cnt[r.entry_slot] != FAIL_MAX) fail_cnt[r.entry_slot]++;
            if (fail_cnt[r.entry_slot] >= BACKOFF_STEPS) begin
              next_due[r.entry_slot] = r.now_ms + BACKOFF_CAP;
            end else begin
              next_due[r.entry_slot] = r.now_ms +
                  (BACKOFF_BASE << (fail_cnt[r.entry_slot] - 8'd1));
            end
            if (round_err == 4'd0) round_err = r.poll_code;
          end
          res.slot_out = r.entry_slot;
          res.delay_ms = next_due[r.entry_slot];
        end
      end
      default: begin
        if (fill_cnt == 0) begin
          res.status = STATUS_REJECT;
          res.delay_ms = 32'd1;
        end else if (r.maximum_delay == 32'd0) begin
          res.delay_ms = 32'd1;
        end else begin
          // shortest distance to any deadline, capped by the limit
          d = r.maximum_delay;
          for (k = 0; k < fill_cnt; k++) begin
            if (is_due(r.now_ms, next_due[k])) begin
              d = 32'd1;
              break;
            end
            c = next_due[k] - r.now_ms;
            if (c < d) d = c;
          end
          if (d == 32'd0) d = 32'd1;
          res.delay_ms = d;
        end
      end
    endcase
    res.round_error = round_err;
    if (func_e'(r.func) != FUNC_SCAN) sched_res_q.push_back(res);
  endfunction

  // Compare one result field and log a mismatch
  function automatic void check_field(input string tag, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: mismatch in %s, expected %0h, actual %0h", $time, tag, want, got);
      err_cnt++;
    end
  endfunction

  function automatic in_req_t rand_req();
    in_req_t r;
    r.func          = 2'($urandom_range(0, 3));
    r.now_ms        = $urandom();
    r.device_id     = 8'($urandom_range(0, 255));
    r.interval_ms   = $urandom();
    r.entry_slot    = 3'($urandom_range(0, 7));
    r.poll_code     = 4'($urandom_range(0, 15));
    r.maximum_delay = $urandom();
    return r;
  endfunction

  task automatic push_req(input func_e f, input logic [31:0] now, input logic [7:0] id,
                          input logic [31:0] per, input logic [2:0] slot,
                          input logic [3:0] code, input logic [31:0] maxd);
    stim_t s;
    s.wait_idle         = 1'b0;
    s.req.func          = f;
    s.req.now_ms        = now;
    s.req.device_id     = id;
    s.req.interval_ms   = per;
    s.req.entry_slot    = slot;
    s.req.poll_code     = code;
    s.req.maximum_delay = maxd;
    poll_req_q.push_back(s);
  endtask

  // Driver: offer queued requests in bursts with random gaps
  always @(posedge clk_i) begin : send_requests
    stim_t nxt;
    bit    held;
    bit    offer;
    if (rst_ni) begin
      held = in_valid && in_stall;
      offer = 1'b0;
      if (in_valid && !in_stall) begin
        run_scheduler(in_req);
        func_cnt[in_req.func]++;
        req_cnt++;
      end
      if (!held && poll_req_q.size() != 0) begin
        if (!(poll_req_q[0].wait_idle && sched_res_q.size() != 0)) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            nxt = poll_req_q.pop_front();
            in_req <= nxt.req;
            offer = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 15);
            end
          end
        end
      end
      in_valid <= held || offer;
    end
  end

  // Monitor: check each accepted result and drive the stall pattern
  always @(posedge clk_i) begin : take_results
    out_res_t want;
    bit       stall_nxt;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        res_cnt++;
        if (sched_res_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_res);
          err_cnt++;
        end else begin
          want = sched_res_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_res.status));
          check_field("slot_out", 32'(want.slot_out), 32'(out_res.slot_out));
          check_field("last", 32'(want.last), 32'(out_res.last));
          check_field("delay_ms", want.delay_ms, out_res.delay_ms);
          check_field("round_error", 32'(want.round_error), 32'(out_res.round_error));
        end
      end
      // long hold-off so the block fills and stalls its input
      if (res_cnt >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at = (next_hold_at == 60) ? 500 : 32'hFFFF_FFFF;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else begin
        case (stall_mode)
          0:       stall_nxt = 1'b0;
          1:       stall_nxt = ($urandom_range(0, 3) == 0);
          2:       stall_nxt = ($urandom_range(0, 3) != 0);
          default: stall_nxt = !out_stall;
        endcase
      end
      out_stall <= stall_nxt;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cyc_cnt++;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cyc_cnt,
               sched_res_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    stim_t       s;
    logic [31:0] t_now;
    logic [7:0]  gen_ids[$];
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    fill_cnt = 0;
    round_err = '0;
    for (k = 0; k < TABLE_SIZE; k++) begin
      next_due[k] = '0;
      fail_cnt[k] = '0;
    end

    // Empty table: scan, query and report are all refused
    push_req(FUNC_SCAN,   32'd0, 8'h00, 32'd0, 3'd0, 4'd0, 32'd0);
    push_req(FUNC_QUERY,  32'd0, 8'h00, 32'd0, 3'd0, 4'd0, 32'd0);
    push_req(FUNC_REPORT, 32'd0, 8'h00, 32'd0, 3'd0, 4'd0, 32'd0);
    // Adds: default period, extreme id and period, duplicate id
    push_req(FUNC_ADD, 32'd0, 8'h00, 32'd0, 3'd0, 4'd0, 32'd0);
    push_req(FUNC_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 3'd7, 4'hF, 32'hFFFF_FFFF);
    push_req(FUNC_ADD, 32'd0, 8'h00, 32'd5, 3'd0, 4'd0, 32'd0);
    // Fresh entries are due
    push_req(FUNC_SCAN,  32'd5, 8'h00, 32'd0, 3'd0, 4'd0, 32'd0);
    push_req(FUNC_QUERY, 32'd5, 8'h00, 32'd0, 3'd0, 4'd0, 32'd100);
    // Success, then the backoff ladder up to the cap, first error kept
    push_req(FUNC_REPORT, 32'd100, 8'h00, 32'd0, 3'd0, 4'd0, 32'd0);
    push_req(FUNC_REPORT, 32'hFFFF_FFFF, 8'h00, 32'd0, 3'd1, 4'hF, 32'd0);
    push_req(FUNC_REPORT, 32'd0, 8'h00, 32'd0, 3'd1, 4'd1, 32'd0);
    push_req(FUNC_REPORT, 32'd0, 8'h00, 32'd0, 3'd1, 4'd2, 32'd0);
    push_req(FUNC_REPORT, 32'd0, 8'h00, 32'd0, 3'd1, 4'd3, 32'd0);
    push_req(FUNC_REPORT, 32'd0, 8'h00, 32'd0, 3'd1, 4'd4, 32'd0);
    // Queries: nearest deadline, limit below it, zero limit
    push_req(FUNC_QUERY, 32'd100, 8'h00, 32'd0, 3'd0, 4'd0, 32'hFFFF_FFFF);
    push_req(FUNC_QUERY, 32'd100, 8'h00, 32'd0, 3'd0, 4'd0, 32'd7);
    push_req(FUNC_QUERY, 32'd100, 8'h00, 32'd0, 3'd0, 4'd0, 32'd0);
    // Nothing due, report to an unused slot
    push_req(FUNC_SCAN,   32'd110, 8'h00, 32'd0, 3'd0, 4'd0, 32'd0);
    push_req(FUNC_REPORT, 32'd110, 8'h00, 32'd0, 3'd7, 4'd5, 32'd0);
    // Deadline that wraps to zero counts as due
    push_req(FUNC_ADD,    32'd0, 8'h5A, 32'd1000, 3'd0, 4'd0, 32'd0);
    push_req(FUNC_REPORT, 32'hFFFF_FC18, 8'h00, 32'd0, 3'd2, 4'd0, 32'd0);
    push_req(FUNC_SCAN,   32'd200, 8'h00, 32'd0, 3'd0, 4'd0, 32'd0);
    push_req(FUNC_REPORT, 32'd200, 8'h00, 32'd0, 3'd0, 4'd9, 32'd0);
    push_req(FUNC_ADD,    32'd200, 8'h80, 32'd1, 3'd0, 4'd0, 32'd0);
    gen_ids = '{8'h00, 8'hFF, 8'h5A, 8'h80};

    // Random traffic around a drifting clock with occasional jumps
    t_now = $urandom();
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n == HAMMER_AT) begin
        // drive one slot far past failure count saturation
        for (k = 0; k < HAMMER_REQS; k++) begin
          s.wait_idle = 1'b0;
          s.req = rand_req();
          s.req.func = FUNC_REPORT;
          s.req.entry_slot = 3'd0;
          s.req.poll_code = 4'($urandom_range(1, 15));
          t_now += $urandom_range(0, 300);
          s.req.now_ms = t_now;
          poll_req_q.push_back(s);
        end
      end
      s.wait_idle = (n == 0) || (n == 90) || (n == 180);
      s.req = rand_req();
      if ($urandom_range(0, 19) == 0) t_now = $urandom();
      else t_now += $urandom_range(0, 600);
      s.req.now_ms = t_now;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        s.req.func = FUNC_ADD;
        pick = $urandom_range(0, 9);
        if (pick == 0) s.req.interval_ms = 32'd0;
        else if (pick > 2) s.req.interval_ms = $urandom_range(1, 2000);
        if ($urandom_range(0, 4) == 0)
          s.req.device_id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
        gen_ids.push_back(s.req.device_id);
      end else if (pick < 40) begin
        s.req.func = FUNC_SCAN;
      end else if (pick < 75) begin
        s.req.func = FUNC_REPORT;
        if ($urandom_range(0, 1) == 0) s.req.poll_code = 4'd0;
      end else begin
        s.req.func = FUNC_QUERY;
        pick = $urandom_range(0, 9);
        if (pick == 0) s.req.maximum_delay = 32'd0;
        else if (pick > 3) s.req.maximum_delay = $urandom_range(1, 3000);
      end
      poll_req_q.push_back(s);
    end
    total_reqs = poll_req_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go in and every result to come out
    while (req_cnt != total_reqs) @(posedge clk_i);
    while (sched_res_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d add, %0d scan, %0d report, %0d query.", req_cnt,
             func_cnt[FUNC_ADD], func_cnt[FUNC_SCAN], func_cnt[FUNC_REPORT],
             func_cnt[FUNC_QUERY]);
    $display("Checked %0d results, %0d due entries listed, %0d mismatches.", res_cnt,
             due_cnt, err_cnt);
    if (err_cnt == 0 && sched_res_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/psb_pkg.sv
rtl/psb_front.sv
rtl/psb_back.sv
rtl/poll_scheduler_backoff.sv
bench/tb_top.sv
